// ===== design/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define CAL_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("circular_array_list assertion failed");

// condition must never be seen out of reset
`define CAL_ASSERT_NEVER(label, clk, rst_n, cond) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("circular_array_list forbidden condition seen");

`endif

// ===== design/cal_pkg.sv =====
`timescale 1ns / 1ps

package cal_pkg;

  // store depth, a power of two so slot arithmetic wraps on its own
  localparam int Slots = 16;
  localparam int IdxW = $clog2(Slots);
  localparam int RankW = 4;
  localparam int CntW = 4;
  localparam int DataW = 32;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t FullCount = cnt_t'(Slots - 1);

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_REMOVE = 2'd1,
    OP_GET    = 2'd2,
    OP_SET    = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_FULL    = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_INVALID = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_SHIFT = 3'b010,
    S_RESP  = 3'b100
  } state_e;

endpackage

// ===== design/circular_array_list.sv =====
`timescale 1ns / 1ps
// get, set and rejected requests go from the input transfer through the response state
// into the output register; add and remove first pass the shift state, one move per entry
// one request at a time: the next transfer is taken once the result loads, and at most
// 7 entries move per request
// reset: asynchronous active low; head and count clear, slot memory is not cleared
module circular_array_list (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                operation_i,
  input  logic [cal_pkg::RankW-1:0] rank_i,
  input  logic signed [cal_pkg::DataW-1:0] element_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [cal_pkg::DataW-1:0] value_o,
  output logic [1:0]                status_o,
  output logic [cal_pkg::CntW-1:0]  item_count_o
);
  import cal_pkg::*;

  `include "assert_macros.svh"

  // slot memory, one synchronous read port and one write port
  logic [DataW-1:0] slot_mem [Slots];
  logic [DataW-1:0] rdata_q;

  state_e state_q, state_d;
  idx_t   head_q, head_d;
  cnt_t   count_q, count_d;

  // move sequencer
  idx_t   src_q, src_d;       // next source slot to read
  logic   down_q, down_d;     // walk direction, 1 walks toward lower slots
  cnt_t   k_q, k_d;           // moves issued so far
  cnt_t   n_q, n_d;           // moves needed
  logic   pend_q, pend_d;     // read data waiting to be written back
  idx_t   wa_q, wa_d;         // where that data goes
  logic   is_add_q, is_add_d; // insert element after the moves
  idx_t   fin_q, fin_d;       // slot of the inserted element

  // request and result holding
  logic [DataW-1:0] elem_q, elem_d;
  status_e          st_q, st_d;
  logic             get_ok_q, get_ok_d;

  logic             out_valid_q, out_valid_d;
  logic [DataW-1:0] value_q, value_d;
  logic [1:0]       status_q, status_d;
  cnt_t             item_count_q, item_count_d;

  // memory port controls
  logic             rd_en;
  idx_t             rd_addr;
  logic             wr_en;
  idx_t             wr_addr;
  logic [DataW-1:0] wr_data;

  logic    in_xfer;
  op_e     op;
  cnt_t    rank_c;
  cnt_t    mid;
  logic    front;
  idx_t    rank_slot;
  status_e st_c;

  assign in_xfer   = in_valid_i && !in_stall_o;
  assign op        = op_e'(operation_i);
  assign rank_c    = cnt_t'(rank_i);
  assign mid       = count_q >> 1;
  assign front     = rank_c < mid;   // shorter side is the front part
  assign rank_slot = head_q + idx_t'(rank_i);

  // request check against the list before the operation
  always_comb begin
    st_c = ST_OK;
    case (op)
      OP_ADD: begin
        if (count_q >= FullCount) st_c = ST_FULL;
        else if (rank_c > count_q) st_c = ST_INVALID;
      end
      OP_REMOVE: begin
        if (count_q == '0) st_c = ST_EMPTY;
        else if (rank_c >= count_q) st_c = ST_INVALID;
      end
      OP_GET, OP_SET: begin
        if (rank_c >= count_q) st_c = ST_INVALID;
      end
      default: st_c = ST_INVALID;
    endcase
  end

  always_comb begin
    state_d   = state_q;
    head_d    = head_q;
    count_d   = count_q;
    src_d     = src_q;
    down_d    = down_q;
    k_d       = k_q;
    n_d       = n_q;
    pend_d    = 1'b0;
    wa_d      = wa_q;
    is_add_d  = is_add_q;
    fin_d     = fin_q;
    elem_d    = elem_q;
    st_d      = st_q;
    get_ok_d  = get_ok_q;

    out_valid_d  = out_valid_q && out_stall_i;
    value_d      = value_q;
    status_d     = status_q;
    item_count_d = item_count_q;

    rd_en   = 1'b0;
    rd_addr = rank_slot;
    wr_en   = 1'b0;
    wr_addr = rank_slot;
    wr_data = element_i;

    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          elem_d   = element_i;
          st_d     = st_c;
          get_ok_d = 1'b0;
          is_add_d = 1'b0;
          k_d      = '0;
          n_d      = '0;
          state_d  = S_RESP;
          if (st_c == ST_OK) begin
            case (op)
              OP_GET: begin
                // read now, data is in rdata_q by the response cycle
                rd_en    = 1'b1;
                get_ok_d = 1'b1;
              end
              OP_SET: begin
                wr_en = 1'b1;
              end
              OP_ADD: begin
                is_add_d = 1'b1;
                count_d  = count_q + cnt_t'(1);
                state_d  = S_SHIFT;
                if (front) begin
                  // front items move one slot down, head steps back
                  src_d  = head_q;
                  down_d = 1'b0;
                  n_d    = rank_c;
                  fin_d  = rank_slot - idx_t'(1);
                  head_d = head_q - idx_t'(1);
                end else begin
                  // back items move one slot up, from the tail
                  src_d  = head_q + idx_t'(count_q) - idx_t'(1);
                  down_d = 1'b1;
                  n_d    = count_q - rank_c;
                  fin_d  = rank_slot;
                end
              end
              OP_REMOVE: begin
                count_d = count_q - cnt_t'(1);
                state_d = S_SHIFT;
                if (front) begin
                  // front items close the gap upward, head steps forward
                  src_d  = rank_slot - idx_t'(1);
                  down_d = 1'b1;
                  n_d    = rank_c;
                  head_d = head_q + idx_t'(1);
                end else begin
                  src_d  = rank_slot + idx_t'(1);
                  down_d = 1'b0;
                  n_d    = count_q - cnt_t'(1) - rank_c;
                end
              end
              default: state_d = S_RESP;
            endcase
          end
        end
      end

      S_SHIFT: begin
        // read move k while writing back move k-1
        if (k_q != n_q) begin
          rd_en   = 1'b1;
          rd_addr = src_q;
          k_d     = k_q + cnt_t'(1);
          pend_d  = 1'b1;
          wa_d    = down_q ? src_q + idx_t'(1) : src_q - idx_t'(1);
          src_d   = down_q ? src_q - idx_t'(1) : src_q + idx_t'(1);
        end
        if (pend_q) begin
          wr_en   = 1'b1;
          wr_addr = wa_q;
          wr_data = rdata_q;
        end else if (k_q == n_q) begin
          // all moves done; for an add, drop the new element into its slot
          wr_en   = is_add_q;
          wr_addr = fin_q;
          wr_data = elem_q;
          state_d = S_RESP;
        end
      end

      S_RESP: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d  = 1'b1;
          value_d      = get_ok_q ? rdata_q : '0;
          status_d     = st_q;
          item_count_d = count_q;
          state_d      = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // memory: registered read, one write
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= slot_mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      head_q      <= '0;
      count_q     <= '0;
      k_q         <= '0;
      n_q         <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      count_q     <= count_d;
      k_q         <= k_d;
      n_q         <= n_d;
      pend_q      <= pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    src_q        <= src_d;
    down_q       <= down_d;
    wa_q         <= wa_d;
    is_add_q     <= is_add_d;
    fin_q        <= fin_d;
    elem_q       <= elem_d;
    st_q         <= st_d;
    get_ok_q     <= get_ok_d;
    value_q      <= value_d;
    status_q     <= status_d;
    item_count_q <= item_count_d;
  end

  assign in_stall_o   = (state_q != S_IDLE);
  assign out_valid_o  = out_valid_q;
  assign value_o      = value_q;
  assign status_o     = status_q;
  assign item_count_o = item_count_q;

  // the sequencer never issues more moves than planned
  `CAL_ASSERT_NEVER(a_moves_bounded, clk_i, rst_ni, k_q > n_q)
  // list size changes only right after an input transfer
  `CAL_ASSERT(a_count_on_xfer, clk_i, rst_ni,
              (count_q != $past(count_q)) |-> $past(in_xfer))
  // a new result is only loaded from the response state
  `CAL_ASSERT(a_result_from_resp, clk_i, rst_ni,
              $rose(out_valid_q) |-> $past(state_q == S_RESP))
  // pending write-back only happens while moving entries
  `CAL_ASSERT(a_pend_in_shift, clk_i, rst_ni, pend_q |-> (state_q == S_SHIFT))
  // list never grows past one less than the store depth
  `CAL_ASSERT_NEVER(a_not_overfull, clk_i, rst_ni,
                    (state_q == S_RESP) && (count_q > FullCount))

endmodule

// ===== sim/circular_array_list_tb.sv =====
`timescale 1ns / 1ps

module circular_array_list_tb;
  import cal_pkg::*;

  typedef struct {
    op_e                     op;
    logic [RankW-1:0]        rank;
    logic signed [DataW-1:0] element;
    bit                      wait_for_drain;  // hold until all results are back
  } list_request_t;

  typedef struct {
    logic signed [DataW-1:0] value;
    status_e                 status;
    cnt_t                    item_count;
  } list_result_t;

  logic                    clk_i;
  logic                    rst_ni;
  logic                    in_valid_i;
  logic                    in_stall_o;
  logic [1:0]              operation_i;
  logic [RankW-1:0]        rank_i;
  logic signed [DataW-1:0] element_i;
  logic                    out_valid_o;
  logic                    out_stall_i;
  logic signed [DataW-1:0] value_o;
  logic [1:0]              status_o;
  logic [CntW-1:0]         item_count_o;

  circular_array_list i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .operation_i (operation_i),
    .rank_i      (rank_i),
    .element_i   (element_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o),
    .item_count_o(item_count_o)
  );

  list_request_t pending_requests[$];
  list_result_t  expected_results[$];
  bit            request_taken;
  int            transfers_in;
  int            error_count;
  int            planned_count;  // list length as the stimulus generator tracks it

  // shadow of the list contents
  logic signed [DataW-1:0] shadow_slots[Slots];
  idx_t                    shadow_head;
  cnt_t                    shadow_count;

  // no random gaps on either side while this window of transfers goes through
  function automatic bit gaps_allowed();
    return !(transfers_in >= 400 && transfers_in < 650);
  endfunction

  function automatic idx_t slot_at(int offset);
    return idx_t'(int'(shadow_head) + offset);
  endfunction

  // performs one request on the shadow list and returns the result it must give
  function automatic list_result_t apply_request(op_e op, logic [RankW-1:0] rank,
                                                 logic signed [DataW-1:0] element);
    int n;
    int r;
    int i;
    list_result_t res;
    n = int'(shadow_count);
    r = int'(rank);
    res.value = '0;
    res.status = ST_OK;
    case (op)
      OP_ADD: begin
        if (n >= Slots - 1) begin
          res.status = ST_FULL;
        end else if (r > n) begin
          res.status = ST_INVALID;
        end else if (r < n / 2) begin
          // front half moves one place toward the head, head steps back
          for (i = 0; i < r; i++) shadow_slots[slot_at(i - 1)] = shadow_slots[slot_at(i)];
          shadow_slots[slot_at(r - 1)] = element;
          shadow_head = shadow_head - 1'b1;
          shadow_count = shadow_count + 1'b1;
        end else begin
          for (i = n; i > r; i--) shadow_slots[slot_at(i)] = shadow_slots[slot_at(i - 1)];
          shadow_slots[slot_at(r)] = element;
          shadow_count = shadow_count + 1'b1;
        end
      end
      OP_REMOVE: begin
        if (n == 0) begin
          res.status = ST_EMPTY;
        end else if (r >= n) begin
          res.status = ST_INVALID;
        end else if (r < n / 2) begin
          for (i = r; i > 0; i--) shadow_slots[slot_at(i)] = shadow_slots[slot_at(i - 1)];
          shadow_head = shadow_head + 1'b1;
          shadow_count = shadow_count - 1'b1;
        end else begin
          for (i = r; i + 1 < n; i++) shadow_slots[slot_at(i)] = shadow_slots[slot_at(i + 1)];
          shadow_count = shadow_count - 1'b1;
        end
      end
      OP_GET: begin
        if (r >= n) res.status = ST_INVALID;
        else res.value = shadow_slots[slot_at(r)];
      end
      default: begin
        if (r >= n) res.status = ST_INVALID;
        else shadow_slots[slot_at(r)] = element;
      end
    endcase
    res.item_count = shadow_count;
    return res;
  endfunction

  // queues a request and tracks the list length it leaves behind
  task automatic queue_request(op_e op, int rank, logic signed [DataW-1:0] element,
                               bit wait_for_drain);
    list_request_t req;
    req.op = op;
    req.rank = RankW'(rank);
    req.element = element;
    req.wait_for_drain = wait_for_drain;
    pending_requests.push_back(req);
    if (op == OP_ADD && planned_count < Slots - 1 && rank <= planned_count) planned_count++;
    if (op == OP_REMOVE && planned_count > 0 && rank < planned_count) planned_count--;
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // fill the request queue, then wait for the last result
  initial begin : stimulus
    int k;
    int roll;
    int rank;
    bit filling;
    op_e op;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    operation_i = OP_ADD;
    rank_i = '0;
    element_i = '0;
    out_stall_i = 1'b0;
    request_taken = 1'b0;
    transfers_in = 0;
    error_count = 0;
    planned_count = 0;
    shadow_head = '0;
    shadow_count = '0;
    foreach (shadow_slots[s]) shadow_slots[s] = '0;

    // empty list: every operation is refused
    queue_request(OP_REMOVE, 0, 32'sd0, 1'b0);
    queue_request(OP_GET, 0, 32'sd0, 1'b0);
    queue_request(OP_SET, 0, 32'sd5, 1'b0);
    queue_request(OP_ADD, 1, 32'sd7, 1'b0);
    // fill to capacity at mixed ranks so both shift directions and the wrap are used
    for (k = 0; k < Slots - 1; k++) begin
      case (k)
        0: queue_request(OP_ADD, 0, 32'sh8000_0000, 1'b0);
        1: queue_request(OP_ADD, 1, 32'sh7fff_ffff, 1'b0);
        2: queue_request(OP_ADD, 0, -32'sd1, 1'b0);
        default: queue_request(OP_ADD, (k * 7) % (k + 1), $urandom(), 1'b0);
      endcase
    end
    queue_request(OP_ADD, 0, 32'sd9, 1'b0);  // full list
    queue_request(OP_GET, 14, 32'sd0, 1'b0);
    queue_request(OP_GET, 15, 32'sd0, 1'b0);  // past the end
    queue_request(OP_SET, 0, 32'sh5a5a_a5a5, 1'b0);
    queue_request(OP_REMOVE, 15, 32'sd0, 1'b0);
    queue_request(OP_REMOVE, 2, 32'sd0, 1'b0);   // front side closes the gap
    queue_request(OP_REMOVE, 10, 32'sd0, 1'b0);  // back side closes the gap

    // random part alternates between growing and shrinking phases
    filling = 1'b1;
    for (k = 0; k < 1000; k++) begin
      if (k % 50 == 0) filling = ~filling;
      roll = $urandom_range(0, 99);
      if (filling) begin
        op = roll < 50 ? OP_ADD : roll < 65 ? OP_REMOVE : roll < 85 ? OP_GET : OP_SET;
      end else begin
        op = roll < 20 ? OP_ADD : roll < 55 ? OP_REMOVE : roll < 80 ? OP_GET : OP_SET;
      end
      if ($urandom_range(0, 99) < 85) begin
        if (op == OP_ADD) rank = $urandom_range(0, planned_count);
        else rank = planned_count == 0 ? 0 : $urandom_range(0, planned_count - 1);
      end else begin
        rank = $urandom_range(0, 15);
      end
      queue_request(op, rank, $urandom(), k == 500);
    end

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    while (pending_requests.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (error_count == 0) begin
      $display("circular_array_list verification clean");
    end else begin
      $display("circular_array_list verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("circular_array_list verification failed");
    $finish;
  end

  // request driver, changes inputs at the falling edge
  always @(negedge clk_i) begin : drive_requests
    list_request_t req;
    if (rst_ni) begin
      if (!in_valid_i || request_taken) begin
        if (pending_requests.size() != 0 &&
            !(pending_requests[0].wait_for_drain && expected_results.size() != 0) &&
            !(gaps_allowed() && $urandom_range(0, 99) < 12)) begin
          req = pending_requests.pop_front();
          operation_i <= req.op;
          rank_i <= req.rank;
          element_i <= req.element;
          in_valid_i <= 1'b1;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // result side back-pressure
  always @(negedge clk_i) begin
    if (rst_ni) out_stall_i <= gaps_allowed() && $urandom_range(0, 99) < 12;
  end

  // monitor: predict on each request transfer, check each result transfer
  always @(posedge clk_i) begin : watch_transfers
    list_result_t want;
    if (rst_ni) begin
      request_taken <= in_valid_i && !in_stall_o;
      if (in_valid_i && !in_stall_o) begin
        expected_results.push_back(apply_request(op_e'(operation_i), rank_i, element_i));
        transfers_in <= transfers_in + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing outstanding");
          error_count++;
        end else begin
          want = expected_results.pop_front();
          if (value_o !== want.value) begin
            $error("value: expected %0d, got %0d", want.value, value_o);
            error_count++;
          end
          if (status_o !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_o);
            error_count++;
          end
          if (item_count_o !== want.item_count) begin
            $error("item_count: expected %0d, got %0d", want.item_count, item_count_o);
            error_count++;
          end
        end
      end
    end
  end

endmodule

// ===== files.f =====
+incdir+design
design/cal_pkg.sv
design/circular_array_list.sv
sim/circular_array_list_tb.sv
